### rtl/line_fixed_string_search_defines.svh
// Assertion helpers for the line search block.
`ifndef LINE_FIXED_STRING_SEARCH_DEFINES_SVH
`define LINE_FIXED_STRING_SEARCH_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LFSS_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define LFSS_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/lfss_pkg.sv
`timescale 1ns / 1ps

package lfss_pkg;

    // Parameter defaults
    localparam int PATTERN_BYTES_DEF = 16;
    localparam int COLUMN_BITS_DEF   = 16;
    localparam int COUNT_BITS_DEF    = 32;

    // Fixed widths
    localparam int PAT_REG_BYTES = 16;
    localparam int PIDX_W        = 4;
    localparam int LEN_W         = 5;
    localparam int LINE_W        = 32;
    localparam int COL_OUT_W     = 16;
    localparam int CNT_OUT_W     = 32;
    localparam int KIND_W        = 2;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [7:0] NEWLINE_BYTE  = 8'd10;
    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET   = 8'd32;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_OCCUR   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_VERDICT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COUNT   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LO      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_HI      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_CASE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_ONLY  = 3'd5;

    typedef enum logic [1:0] {
        OP_TEXT,
        OP_NEWLINE,
        OP_END
    } t_op;

    typedef struct packed {
        t_op  op;
        logic hit;      // text byte completes a pattern match
        logic pending;  // line had bytes before this transaction
    } t_cmd_ctl;

    typedef struct packed {
        logic [8*PAT_REG_BYTES-1:0] pattern;
        logic [LEN_W-1:0]           length;
        logic                       ignore_case;
    } t_match_cfg;

    typedef struct packed {
        logic invert_match;
        logic count_only;
    } t_line_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic fold_en);
        if (fold_en && (b >= ASCII_UPPER_A) && (b <= ASCII_UPPER_Z)) begin
            return b + CASE_OFFSET;
        end
        return b;
    endfunction

endpackage

### rtl/lfss_in_if.sv
`timescale 1ns / 1ps

interface lfss_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       stream_end;

    modport source (output valid, output text_byte, output stream_end, input ready);
    modport sink (input valid, input text_byte, input stream_end, output ready);
endinterface

### rtl/lfss_out_if.sv
`timescale 1ns / 1ps

interface lfss_out_if import lfss_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    result_kind;
    logic [LINE_W-1:0]    line_index;
    logic [COL_OUT_W-1:0] match_column;
    logic                 line_selected;
    logic [CNT_OUT_W-1:0] selected_count;
    logic                 last_result;

    modport source (
        output valid, output result_kind, output line_index, output match_column,
        output line_selected, output selected_count, output last_result, input ready
    );
    modport sink (
        input valid, input result_kind, input line_index, input match_column,
        input line_selected, input selected_count, input last_result, output ready
    );
endinterface

### rtl/lfss_front.sv
`timescale 1ns / 1ps

// Front: byte window, line position and parallel pattern compare.
module lfss_front import lfss_pkg::*; #(
    parameter int PATTERN_BYTES = PATTERN_BYTES_DEF,
    parameter int COLUMN_BITS   = COLUMN_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_match_cfg             i_cfg,
    input  logic                   i_take,
    input  logic [7:0]             i_text_byte,
    input  logic                   i_stream_end,
    output t_cmd_ctl               o_ctl,
    output logic [COLUMN_BITS-1:0] o_start,
    output logic [COLUMN_BITS-1:0] o_next_start
);

    localparam int WIN = (PATTERN_BYTES < PAT_REG_BYTES) ? PATTERN_BYTES : PAT_REG_BYTES;
    localparam int PW  = COLUMN_BITS + 1;
    localparam logic [COLUMN_BITS-1:0] COL_MAX = '1;

    logic [7:0]             r_window [WIN];
    logic [7:0]             n_window [WIN];
    logic [COLUMN_BITS-1:0] r_pos;
    logic [COLUMN_BITS-1:0] n_pos;

    logic [LEN_W-1:0]       w_len;
    logic [LEN_W-1:0]       w_pidx [WIN];
    logic [WIN-1:0]         w_byte_ok;
    logic [PW-1:0]          w_pos_inc;
    logic [PW-1:0]          w_start_wide;
    logic                   w_long_enough;

    // Effective length: zero acts as one, clipped to the window
    always_comb begin
        priority if (i_cfg.length == '0) begin
            w_len = LEN_W'(1);
        end else if (i_cfg.length > LEN_W'(WIN)) begin
            w_len = LEN_W'(WIN);
        end else begin
            w_len = i_cfg.length;
        end
    end

    // Window as it stands once this byte is in
    always_comb begin
        n_window[0] = i_text_byte;
        for (int j = 1; j < WIN; j++) begin
            n_window[j] = r_window[j-1];
        end
    end

    // Window slot j holds the byte that meets pattern byte len-1-j
    always_comb begin
        for (int j = 0; j < WIN; j++) begin
            w_pidx[j]    = w_len - LEN_W'(1) - LEN_W'(j);
            w_byte_ok[j] = (LEN_W'(j) >= w_len) ||
                (fold_byte(n_window[j], i_cfg.ignore_case) ==
                 fold_byte(i_cfg.pattern[{w_pidx[j][PIDX_W-1:0], 3'b000} +: 8],
                           i_cfg.ignore_case));
        end
    end

    assign w_pos_inc     = {1'b0, r_pos} + PW'(1);
    assign w_long_enough = w_pos_inc >= PW'(w_len);
    assign w_start_wide  = w_pos_inc - PW'(w_len);
    assign o_start       = w_start_wide[COLUMN_BITS-1:0];
    assign o_next_start  = (r_pos == COL_MAX) ? COL_MAX : w_pos_inc[COLUMN_BITS-1:0];

    always_comb begin
        priority if (i_stream_end) begin
            o_ctl.op = OP_END;
        end else if (i_text_byte == NEWLINE_BYTE) begin
            o_ctl.op = OP_NEWLINE;
        end else begin
            o_ctl.op = OP_TEXT;
        end
        o_ctl.hit     = w_long_enough && (&w_byte_ok);
        o_ctl.pending = (r_pos != '0);
    end

    always_comb begin
        n_pos = r_pos;
        if (i_take) begin
            unique case (o_ctl.op)
                OP_TEXT:    n_pos = o_next_start;
                OP_NEWLINE: n_pos = '0;
                OP_END:     n_pos = '0;
                default:    n_pos = r_pos;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    // Stale bytes never reach the compare: position gates the hit
    always_ff @(posedge i_clk) begin
        if (i_take && (o_ctl.op == OP_TEXT)) begin
            r_window <= n_window;
        end
    end

endmodule

### rtl/lfss_queue.sv
`timescale 1ns / 1ps

// Small show-ahead FIFO between front and back.
module lfss_queue import lfss_pkg::*; #(
    parameter int W     = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [W-1:0]  i_data,
    input  logic          i_pop,
    output logic [W-1:0]  o_data,
    output t_queue_status o_status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] n_wr;
    logic [AW-1:0] r_rd;
    logic [AW-1:0] n_rd;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + CW'(1);
            2'b01:   n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data         = r_mem[r_rd];
    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

### rtl/lfss_back.sv
`timescale 1ns / 1ps

// Back: line bookkeeping, verdicts, counts, output register.
module lfss_back import lfss_pkg::*; #(
    parameter int COLUMN_BITS = COLUMN_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_line_cfg              i_cfg,
    input  t_queue_status          i_q_status,
    input  t_cmd_ctl               i_ctl,
    input  logic [COLUMN_BITS-1:0] i_start,
    input  logic [COLUMN_BITS-1:0] i_next_start,
    output logic                   o_pop,
    lfss_out_if.source             o_result
);

    localparam logic [LINE_W-1:0]     LINE_MAX = '1;
    localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;

    logic [COLUMN_BITS-1:0] r_next_allowed;
    logic [COLUMN_BITS-1:0] n_next_allowed;
    logic                   r_has_occ;
    logic                   n_has_occ;
    logic [LINE_W-1:0]      r_line;
    logic [LINE_W-1:0]      n_line;
    logic [COUNT_BITS-1:0]  r_selected;
    logic [COUNT_BITS-1:0]  n_selected;

    logic                   r_out_valid;
    logic                   n_out_valid;
    logic [KIND_W-1:0]      r_kind;
    logic [KIND_W-1:0]      n_kind;
    logic [LINE_W-1:0]      r_line_num;
    logic [LINE_W-1:0]      n_line_num;
    logic [COL_OUT_W-1:0]   r_col;
    logic [COL_OUT_W-1:0]   n_col;
    logic                   r_sel;
    logic                   n_sel;
    logic [CNT_OUT_W-1:0]   r_cnt;
    logic [CNT_OUT_W-1:0]   n_cnt;

    logic                   w_can_emit;
    logic                   w_emit;
    logic                   w_line_sel;
    logic [COUNT_BITS-1:0]  w_sel_inc;
    logic [LINE_W-1:0]      w_line_inc;

    assign w_can_emit = !r_out_valid || o_result.ready;
    assign o_pop      = !i_q_status.empty && w_can_emit;

    assign w_line_sel = r_has_occ ^ i_cfg.invert_match;
    assign w_sel_inc  = (w_line_sel && (r_selected != CNT_MAX)) ?
                        r_selected + COUNT_BITS'(1) : r_selected;
    assign w_line_inc = (r_line != LINE_MAX) ? r_line + LINE_W'(1) : r_line;

    always_comb begin
        n_next_allowed = r_next_allowed;
        n_has_occ      = r_has_occ;
        n_line         = r_line;
        n_selected     = r_selected;
        w_emit         = 1'b0;
        n_kind         = KIND_OCCUR;
        n_line_num     = '0;
        n_col          = '0;
        n_sel          = 1'b0;
        n_cnt          = '0;
        if (o_pop) begin
            unique case (i_ctl.op)
                OP_TEXT: begin
                    if (i_ctl.hit) begin
                        n_has_occ = 1'b1;
                        // leftmost, non-overlapping: earlier ones block
                        if (i_start >= r_next_allowed) begin
                            w_emit         = 1'b1;
                            n_kind         = KIND_OCCUR;
                            n_line_num     = r_line;
                            n_col          = COL_OUT_W'(i_start);
                            n_next_allowed = i_next_start;
                        end
                    end
                end
                OP_NEWLINE: begin
                    n_selected     = w_sel_inc;
                    n_line         = w_line_inc;
                    n_has_occ      = 1'b0;
                    n_next_allowed = '0;
                    if (!i_cfg.count_only) begin
                        w_emit     = 1'b1;
                        n_kind     = KIND_VERDICT;
                        n_line_num = r_line;
                        n_sel      = w_line_sel;
                    end
                end
                OP_END: begin
                    // unterminated last line gets its verdict here
                    if (i_ctl.pending && !i_cfg.count_only) begin
                        w_emit     = 1'b1;
                        n_kind     = KIND_VERDICT;
                        n_line_num = r_line;
                        n_sel      = w_line_sel;
                    end
                    if (i_cfg.count_only) begin
                        w_emit = 1'b1;
                        n_kind = KIND_COUNT;
                        n_cnt  = CNT_OUT_W'(i_ctl.pending ? w_sel_inc : r_selected);
                    end
                    n_line         = LINE_W'(1);
                    n_selected     = '0;
                    n_has_occ      = 1'b0;
                    n_next_allowed = '0;
                end
                default: begin
                    w_emit = 1'b0;
                end
            endcase
        end
        n_out_valid = w_emit || (r_out_valid && !o_result.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_allowed <= '0;
            r_has_occ      <= 1'b0;
            r_line         <= LINE_W'(1);
            r_selected     <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_next_allowed <= n_next_allowed;
            r_has_occ      <= n_has_occ;
            r_line         <= n_line;
            r_selected     <= n_selected;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_kind     <= n_kind;
            r_line_num <= n_line_num;
            r_col      <= n_col;
            r_sel      <= n_sel;
            r_cnt      <= n_cnt;
        end
    end

    // Every transaction yields at most one result, so each is the last
    assign o_result.valid          = r_out_valid;
    assign o_result.result_kind    = r_kind;
    assign o_result.line_index     = r_line_num;
    assign o_result.match_column   = r_col;
    assign o_result.line_selected  = r_sel;
    assign o_result.selected_count = r_cnt;
    assign o_result.last_result    = r_out_valid;

endmodule

### rtl/line_fixed_string_search.sv
`timescale 1ns / 1ps
`include "line_fixed_string_search_defines.svh"

// Line-oriented fixed-string search. Takes one text byte (or a stream-end
// marker) per transaction and accepts one every cycle while the queue has
// space; the front compares the configured 1..16 byte pattern against the
// byte window in parallel in the cycle the byte arrives, so throughput is
// one byte per clock whenever results are drained as fast. Each input
// transaction produces at most one result: an occurrence on the byte that
// completes a match, a line verdict on newline (or on stream end for an
// unterminated line), or the selected-line count on stream end in count
// mode. The queue is written at the accepting edge, and the back loads its
// output register when it pops the entry; result valid comes from that
// register. A four-entry queue separates front and back, so the input keeps
// flowing until the queue is full while the result side stalls; the back
// retires one queued transaction per cycle when its output register is free
// or being taken. Pattern registers and mode bits must only be written while
// the block is idle. There is no clearing pass after reset.
module line_fixed_string_search import lfss_pkg::*; #(
    parameter int PATTERN_BYTES = PATTERN_BYTES_DEF,
    parameter int COLUMN_BITS   = COLUMN_BITS_DEF,
    parameter int COUNT_BITS    = COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    lfss_in_if.sink               i_text,
    lfss_out_if.source            o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int Q_W = $bits(t_cmd_ctl) + 2 * COLUMN_BITS;

    // Configuration registers
    logic [CFG_DATA_W-1:0] r_pat_lo;
    logic [CFG_DATA_W-1:0] r_pat_hi;
    logic [LEN_W-1:0]      r_pat_len;
    logic                  r_ignore_case;
    logic                  r_invert;
    logic                  r_count_only;

    t_match_cfg             w_match_cfg;
    t_line_cfg              w_line_cfg;
    logic                   w_take;
    t_cmd_ctl               w_front_ctl;
    logic [COLUMN_BITS-1:0] w_front_start;
    logic [COLUMN_BITS-1:0] w_front_next;
    logic [Q_W-1:0]         w_q_in;
    logic [Q_W-1:0]         w_q_out;
    t_queue_status          w_q_status;
    t_cmd_ctl               w_q_ctl;
    logic [COLUMN_BITS-1:0] w_q_start;
    logic [COLUMN_BITS-1:0] w_q_next;
    logic                   w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo      <= '0;
            r_pat_hi      <= '0;
            r_pat_len     <= LEN_W'(1);
            r_ignore_case <= 1'b0;
            r_invert      <= 1'b0;
            r_count_only  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PAT_LO:      r_pat_lo      <= i_cfg_data;
                CFG_PAT_HI:      r_pat_hi      <= i_cfg_data;
                CFG_PAT_LEN:     r_pat_len     <= i_cfg_data[LEN_W-1:0];
                CFG_IGNORE_CASE: r_ignore_case <= i_cfg_data[0];
                CFG_INVERT:      r_invert      <= i_cfg_data[0];
                CFG_COUNT_ONLY:  r_count_only  <= i_cfg_data[0];
                default: begin
                    // writes past the register list are dropped
                    r_count_only <= r_count_only;
                end
            endcase
        end
    end

    // Pattern byte 0 sits in bits 7:0 of the low word
    assign w_match_cfg.pattern     = {r_pat_hi, r_pat_lo};
    assign w_match_cfg.length      = r_pat_len;
    assign w_match_cfg.ignore_case = r_ignore_case;
    assign w_line_cfg.invert_match = r_invert;
    assign w_line_cfg.count_only   = r_count_only;

    // Input side only waits on queue space
    assign i_text.ready = !w_q_status.full;
    assign w_take       = i_text.valid && i_text.ready;

    lfss_front #(
        .PATTERN_BYTES (PATTERN_BYTES),
        .COLUMN_BITS   (COLUMN_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_match_cfg),
        .i_take       (w_take),
        .i_text_byte  (i_text.text_byte),
        .i_stream_end (i_text.stream_end),
        .o_ctl        (w_front_ctl),
        .o_start      (w_front_start),
        .o_next_start (w_front_next)
    );

    assign w_q_in = {w_front_ctl, w_front_start, w_front_next};

    lfss_queue #(
        .W     (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_take),
        .i_data   (w_q_in),
        .i_pop    (w_pop),
        .o_data   (w_q_out),
        .o_status (w_q_status)
    );

    assign {w_q_ctl, w_q_start, w_q_next} = w_q_out;

    lfss_back #(
        .COLUMN_BITS (COLUMN_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_line_cfg),
        .i_q_status   (w_q_status),
        .i_ctl        (w_q_ctl),
        .i_start      (w_q_start),
        .i_next_start (w_q_next),
        .o_pop        (w_pop),
        .o_result     (o_result)
    );

    // Checks
    `LFSS_ASSERT_IMP(a_no_verdict_in_count_mode, i_clk, i_rst_n, o_result.valid && r_count_only, o_result.result_kind != KIND_VERDICT, "line verdict issued in count mode")
    `LFSS_ASSERT_IMP(a_count_fields_clear, i_clk, i_rst_n, o_result.valid && (o_result.result_kind == KIND_COUNT), (o_result.line_index == '0) && (o_result.match_column == '0), "count result carries line fields")
    `LFSS_ASSERT_IMP(a_occur_fields_clear, i_clk, i_rst_n, o_result.valid && (o_result.result_kind == KIND_OCCUR), !o_result.line_selected && (o_result.selected_count == '0), "occurrence carries verdict fields")
    `LFSS_ASSERT_NXT(a_count_end_queued, i_clk, i_rst_n, w_take && i_text.stream_end && r_count_only, !w_q_status.empty, "stream end in count mode lost before back end")

endmodule
